// ===== rtl/owbm_pkg.sv =====
`default_nettype none

package owbm_pkg;

	localparam int TIMER_WIDTH = 10;
	localparam int BITS_PER_BYTE = 8;
	localparam int CFG_WIDTH = 10;
	localparam int DATA_WIDTH = 8;
	localparam int BITS_WIDTH = 4;
	localparam int OP_WIDTH = 3;
	localparam int STATUS_WIDTH = 2;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int TIMER_MAX = (1 << TIMER_WIDTH) - 1;
	localparam int EFF_WIDTH = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
	localparam int SUM_WIDTH = EFF_WIDTH + 1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_END  = 3'd3,
		PH_SLOT     = 3'd4
	} phase_t;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_NONE       = 3'd0,
		OP_RESET      = 3'd1,
		OP_WRITE_BIT  = 3'd2,
		OP_READ_BIT   = 3'd3,
		OP_WRITE_BYTE = 3'd4,
		OP_READ_BYTE  = 3'd5
	} op_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_RESET_LOW      = 3'd0,
		REG_PRESENCE_WAIT  = 3'd1,
		REG_PRESENCE_END   = 3'd2,
		REG_WRITE_ONE_LOW  = 3'd3,
		REG_WRITE_ZERO_LOW = 3'd4,
		REG_READ_LOW       = 3'd5,
		REG_READ_SAMPLE    = 3'd6,
		REG_SLOT           = 3'd7
	} cfg_index_t;

	localparam logic [STATUS_WIDTH-1:0] ST_PRESENCE_OK = 2'd0;
	localparam logic [STATUS_WIDTH-1:0] ST_NO_PULLDOWN = 2'd1;
	localparam logic [STATUS_WIDTH-1:0] ST_NOT_RELEASED = 2'd2;

	typedef struct packed {
		logic [OP_WIDTH-1:0]   operation;
		logic [DATA_WIDTH-1:0] write_data;
		logic                  line_level;
	} in_item_t;

	typedef struct packed {
		logic                    drive_low;
		logic                    busy_res;
		logic                    done_res;
		logic [DATA_WIDTH-1:0]   read_data;
		logic [STATUS_WIDTH-1:0] bus_status;
	} out_item_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] reset_low_time;
		logic [CFG_WIDTH-1:0] presence_wait_time;
		logic [CFG_WIDTH-1:0] presence_end_time;
		logic [CFG_WIDTH-1:0] write_one_low_time;
		logic [CFG_WIDTH-1:0] write_zero_low_time;
		logic [CFG_WIDTH-1:0] read_low_time;
		logic [CFG_WIDTH-1:0] read_sample_time;
		logic [CFG_WIDTH-1:0] slot_time;
	} cfg_t;

	// A zero time acts as one, and every time is capped at the timer range.
	function automatic logic [TIMER_WIDTH-1:0] eff_time(input logic [CFG_WIDTH-1:0] v);
		logic [EFF_WIDTH-1:0] x;
		x = EFF_WIDTH'(v);
		if (x == '0) begin
			x = EFF_WIDTH'(1);
		end
		if (x > EFF_WIDTH'(TIMER_MAX)) begin
			x = EFF_WIDTH'(TIMER_MAX);
		end
		return TIMER_WIDTH'(x);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/onewire_bus_master_top.sv =====
// Output: the result item for a tick is registered and presented in the cycle after that tick is accepted.
// Throughput: one tick item per cycle; the single output register lets a new item
// enter whenever that register is empty or being taken in the same cycle.
// Reset: arst_n clears the bus state to idle and loads the timing registers with
// their default values; no clearing pass is needed.
`default_nettype none

module onewire_bus_master_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire owbm_pkg::in_item_t                     in_data,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output owbm_pkg::out_item_t                         out_data,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [owbm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  wire logic [owbm_pkg::CFG_WIDTH-1:0]         cfg_data
);

	owbm_pkg::cfg_t cfg_q;
	owbm_pkg::out_item_t result;
	owbm_pkg::out_item_t out_q;
	logic out_valid_q;
	logic step;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign step = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	owbm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_data),
		.cfg    (cfg_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time <= owbm_pkg::CFG_WIDTH'(480);
			cfg_q.presence_wait_time <= owbm_pkg::CFG_WIDTH'(40);
			cfg_q.presence_end_time <= owbm_pkg::CFG_WIDTH'(300);
			cfg_q.write_one_low_time <= owbm_pkg::CFG_WIDTH'(5);
			cfg_q.write_zero_low_time <= owbm_pkg::CFG_WIDTH'(60);
			cfg_q.read_low_time <= owbm_pkg::CFG_WIDTH'(5);
			cfg_q.read_sample_time <= owbm_pkg::CFG_WIDTH'(10);
			cfg_q.slot_time <= owbm_pkg::CFG_WIDTH'(61);
		end else if (cfg_valid && cfg_ready) begin
			unique case (owbm_pkg::cfg_index_t'(cfg_index))
				owbm_pkg::REG_RESET_LOW:      cfg_q.reset_low_time <= cfg_data;
				owbm_pkg::REG_PRESENCE_WAIT:  cfg_q.presence_wait_time <= cfg_data;
				owbm_pkg::REG_PRESENCE_END:   cfg_q.presence_end_time <= cfg_data;
				owbm_pkg::REG_WRITE_ONE_LOW:  cfg_q.write_one_low_time <= cfg_data;
				owbm_pkg::REG_WRITE_ZERO_LOW: cfg_q.write_zero_low_time <= cfg_data;
				owbm_pkg::REG_READ_LOW:       cfg_q.read_low_time <= cfg_data;
				owbm_pkg::REG_READ_SAMPLE:    cfg_q.read_sample_time <= cfg_data;
				owbm_pkg::REG_SLOT:           cfg_q.slot_time <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/owbm_engine.sv =====
`default_nettype none

module owbm_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire owbm_pkg::in_item_t item,
	input  wire owbm_pkg::cfg_t    cfg,
	output owbm_pkg::out_item_t    result
);

	localparam int TW = owbm_pkg::TIMER_WIDTH;
	localparam int DW = owbm_pkg::DATA_WIDTH;
	localparam int BW = owbm_pkg::BITS_WIDTH;
	localparam int SW = owbm_pkg::SUM_WIDTH;

	owbm_pkg::phase_t phase_q, phase_a, phase_d;
	logic [TW-1:0] cnt_q, cnt_a, cnt_d, cnt_inc;
	logic [DW-1:0] shift_q, shift_a, shift_d;
	logic [BW-1:0] bits_q, bits_a, bits_d, bits_dec;
	logic read_mode_q, read_mode_a;
	logic byte_op_q, byte_op_a;
	logic [DW-1:0] read_value_q, read_value_d;
	logic [owbm_pkg::STATUS_WIDTH-1:0] status_q, status_d;

	logic [TW-1:0] low_time, slot_len, slot_m1;
	logic [SW-1:0] sample_point;
	logic low_hit, wait_hit, end_hit, sample_hit, slot_end;

	// Command dispatch: the accepting tick is already the first tick of the command.
	always_comb begin
		phase_a = phase_q;
		cnt_a = cnt_q;
		shift_a = shift_q;
		bits_a = bits_q;
		read_mode_a = read_mode_q;
		byte_op_a = byte_op_q;
		if (phase_q == owbm_pkg::PH_IDLE) begin
			case (owbm_pkg::op_t'(item.operation))
				owbm_pkg::OP_RESET: begin
					phase_a = owbm_pkg::PH_RST_LOW;
					cnt_a = '0;
				end
				owbm_pkg::OP_WRITE_BIT: begin
					phase_a = owbm_pkg::PH_SLOT;
					cnt_a = '0;
					shift_a = DW'(item.write_data[0]);
					bits_a = BW'(1);
					read_mode_a = 1'b0;
					byte_op_a = 1'b0;
				end
				owbm_pkg::OP_READ_BIT: begin
					phase_a = owbm_pkg::PH_SLOT;
					cnt_a = '0;
					shift_a = '0;
					bits_a = BW'(1);
					read_mode_a = 1'b1;
					byte_op_a = 1'b0;
				end
				owbm_pkg::OP_WRITE_BYTE: begin
					phase_a = owbm_pkg::PH_SLOT;
					cnt_a = '0;
					shift_a = item.write_data;
					bits_a = BW'(owbm_pkg::BITS_PER_BYTE);
					read_mode_a = 1'b0;
					byte_op_a = 1'b1;
				end
				owbm_pkg::OP_READ_BYTE: begin
					phase_a = owbm_pkg::PH_SLOT;
					cnt_a = '0;
					shift_a = '0;
					bits_a = BW'(owbm_pkg::BITS_PER_BYTE);
					read_mode_a = 1'b1;
					byte_op_a = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cnt_inc = cnt_a + TW'(1);
		bits_dec = bits_a - BW'(1);
		low_hit = cnt_inc >= owbm_pkg::eff_time(cfg.reset_low_time);
		wait_hit = cnt_inc >= owbm_pkg::eff_time(cfg.presence_wait_time);
		end_hit = cnt_inc >= owbm_pkg::eff_time(cfg.presence_end_time);
		if (read_mode_a) begin
			low_time = owbm_pkg::eff_time(cfg.read_low_time);
		end else if (shift_a[0]) begin
			low_time = owbm_pkg::eff_time(cfg.write_one_low_time);
		end else begin
			low_time = owbm_pkg::eff_time(cfg.write_zero_low_time);
		end
		if (cfg.slot_time < owbm_pkg::CFG_WIDTH'(2)) begin
			slot_len = TW'(2);
		end else begin
			slot_len = owbm_pkg::eff_time(cfg.slot_time);
		end
		slot_m1 = slot_len - TW'(1);
		sample_point = SW'(low_time) + SW'(cfg.read_sample_time);
		if (sample_point > SW'(slot_m1)) begin
			sample_point = SW'(slot_m1);
		end
		sample_hit = SW'(cnt_a) == sample_point;
		slot_end = ({1'b0, cnt_a} + (TW + 1)'(1)) >= {1'b0, slot_len};
	end

	always_comb begin
		phase_d = phase_a;
		unique case (phase_a)
			owbm_pkg::PH_IDLE: begin
			end
			owbm_pkg::PH_RST_LOW: begin
				if (low_hit) begin
					phase_d = owbm_pkg::PH_RST_WAIT;
				end
			end
			owbm_pkg::PH_RST_WAIT: begin
				if (wait_hit) begin
					phase_d = item.line_level ? owbm_pkg::PH_IDLE : owbm_pkg::PH_RST_END;
				end
			end
			owbm_pkg::PH_RST_END: begin
				if (end_hit) begin
					phase_d = owbm_pkg::PH_IDLE;
				end
			end
			owbm_pkg::PH_SLOT: begin
				if (slot_end && bits_dec == '0) begin
					phase_d = owbm_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = owbm_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_a;
		shift_d = shift_a;
		bits_d = bits_a;
		read_value_d = read_value_q;
		status_d = status_q;
		result.drive_low = 1'b0;
		result.done_res = 1'b0;
		unique case (phase_a)
			owbm_pkg::PH_IDLE: begin
			end
			owbm_pkg::PH_RST_LOW: begin
				result.drive_low = 1'b1;
				cnt_d = low_hit ? '0 : cnt_inc;
			end
			owbm_pkg::PH_RST_WAIT: begin
				cnt_d = cnt_inc;
				if (wait_hit) begin
					cnt_d = '0;
					if (item.line_level) begin
						status_d = owbm_pkg::ST_NO_PULLDOWN;
						result.done_res = 1'b1;
					end
				end
			end
			owbm_pkg::PH_RST_END: begin
				cnt_d = cnt_inc;
				if (end_hit) begin
					cnt_d = '0;
					status_d = item.line_level ? owbm_pkg::ST_PRESENCE_OK
						: owbm_pkg::ST_NOT_RELEASED;
					result.done_res = 1'b1;
				end
			end
			owbm_pkg::PH_SLOT: begin
				result.drive_low = cnt_a < low_time;
				if (read_mode_a && sample_hit) begin
					if (byte_op_a) begin
						shift_d = {item.line_level, shift_a[DW-1:1]};
					end else begin
						read_value_d = DW'(item.line_level);
					end
				end
				if (slot_end) begin
					if (!read_mode_a) begin
						shift_d = {1'b0, shift_a[DW-1:1]};
					end
					bits_d = bits_dec;
					cnt_d = '0;
					if (bits_dec == '0) begin
						if (read_mode_a && byte_op_a) begin
							read_value_d = shift_d;
						end
						result.done_res = 1'b1;
					end
				end else begin
					cnt_d = cnt_inc;
				end
			end
			default: begin
			end
		endcase
		result.busy_res = phase_d != owbm_pkg::PH_IDLE;
		result.read_data = read_value_d;
		result.bus_status = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owbm_pkg::PH_IDLE;
			cnt_q <= '0;
			shift_q <= '0;
			bits_q <= '0;
			read_mode_q <= 1'b0;
			byte_op_q <= 1'b0;
			read_value_q <= '0;
			status_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d;
			shift_q <= shift_d;
			bits_q <= bits_d;
			read_mode_q <= read_mode_a;
			byte_op_q <= byte_op_a;
			read_value_q <= read_value_d;
			status_q <= status_d;
		end
	end

endmodule

`default_nettype wire

// ===== dv/onewire_bus_checker.sv =====
`timescale 1ns / 1ps

module onewire_bus_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire owbm_pkg::in_item_t                   in_data,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready,
	input  wire owbm_pkg::out_item_t                  out_data,
	input  wire logic                                 cfg_valid,
	input  wire logic                                 cfg_ready,
	input  wire logic [owbm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [owbm_pkg::CFG_WIDTH-1:0]       cfg_data,
	output int                                        failures,
	output int                                        waiting,
	output int                                        checked,
	output logic                                      bus_active
);
	import owbm_pkg::*;

	localparam cfg_t RESET_TIMING = '{
		reset_low_time: 10'd480, presence_wait_time: 10'd40, presence_end_time: 10'd300,
		write_one_low_time: 10'd5, write_zero_low_time: 10'd60, read_low_time: 10'd5,
		read_sample_time: 10'd10, slot_time: 10'd61
	};

	cfg_t                     timing;
	phase_t                   ph;
	logic [TIMER_WIDTH-1:0]   ticks;
	logic [DATA_WIDTH-1:0]    shreg;
	logic [DATA_WIDTH-1:0]    rd_val;
	logic [BITS_WIDTH-1:0]    bits_rem;
	logic                     rd_mode;
	logic                     byte_mode;
	logic [STATUS_WIDTH-1:0]  status;
	out_item_t                owed_results[$];
	out_item_t                want;
	out_item_t                predicted;
	int                       errs;
	int                       seen;

	function automatic int span(input logic [CFG_WIDTH-1:0] v);
		int n;
		n = (v == '0) ? 1 : int'(v);
		return (n > TIMER_MAX) ? TIMER_MAX : n;
	endfunction

	task automatic start_slots(input logic rd, input logic [DATA_WIDTH-1:0] data,
			input int nbits, input logic bytes);
		ph = PH_SLOT;
		rd_mode = rd;
		shreg = data;
		bits_rem = BITS_WIDTH'(nbits);
		byte_mode = bytes;
		ticks = '0;
	endtask

	task automatic bus_tick(input in_item_t it, output out_item_t r);
		int low;
		int slot;
		int sample_at;
		int c;
		logic drv;
		logic fin;
		drv = 1'b0;
		fin = 1'b0;
		if (ph == PH_IDLE) begin
			case (it.operation)
				OP_RESET: begin
					ph = PH_RST_LOW;
					ticks = '0;
				end
				OP_WRITE_BIT: start_slots(1'b0, {{(DATA_WIDTH-1){1'b0}}, it.write_data[0]}, 1, 1'b0);
				OP_READ_BIT: start_slots(1'b1, '0, 1, 1'b0);
				OP_WRITE_BYTE: start_slots(1'b0, it.write_data, BITS_PER_BYTE, 1'b1);
				OP_READ_BYTE: start_slots(1'b1, '0, BITS_PER_BYTE, 1'b1);
				default: ;
			endcase
		end
		case (ph)
			PH_RST_LOW: begin
				drv = 1'b1;
				ticks = ticks + 1'b1;
				if (int'(ticks) >= span(timing.reset_low_time)) begin
					ph = PH_RST_WAIT;
					ticks = '0;
				end
			end
			PH_RST_WAIT: begin
				ticks = ticks + 1'b1;
				if (int'(ticks) >= span(timing.presence_wait_time)) begin
					if (it.line_level) begin
						status = ST_NO_PULLDOWN;
						ph = PH_IDLE;
						fin = 1'b1;
					end else begin
						ph = PH_RST_END;
					end
					ticks = '0;
				end
			end
			PH_RST_END: begin
				ticks = ticks + 1'b1;
				if (int'(ticks) >= span(timing.presence_end_time)) begin
					status = it.line_level ? ST_PRESENCE_OK : ST_NOT_RELEASED;
					ph = PH_IDLE;
					ticks = '0;
					fin = 1'b1;
				end
			end
			PH_SLOT: begin
				c = int'(ticks);
				if (rd_mode) begin
					low = span(timing.read_low_time);
				end else begin
					low = span(shreg[0] ? timing.write_one_low_time : timing.write_zero_low_time);
				end
				slot = (timing.slot_time < 2) ? 2 : span(timing.slot_time);
				drv = (c < low);
				if (rd_mode) begin
					sample_at = low + int'(timing.read_sample_time);
					if (sample_at > slot - 1) begin
						sample_at = slot - 1;
					end
					if (c == sample_at) begin
						if (byte_mode) begin
							shreg = {it.line_level, shreg[DATA_WIDTH-1:1]};
						end else begin
							rd_val = {{(DATA_WIDTH-1){1'b0}}, it.line_level};
						end
					end
				end
				if (c + 1 >= slot) begin
					if (!rd_mode) begin
						shreg = shreg >> 1;
					end
					bits_rem = bits_rem - 1'b1;
					ticks = '0;
					if (bits_rem == '0) begin
						if (rd_mode && byte_mode) begin
							rd_val = shreg;
						end
						ph = PH_IDLE;
						fin = 1'b1;
					end
				end else begin
					ticks = ticks + 1'b1;
				end
			end
			default: ;
		endcase
		r.drive_low = drv;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.read_data = rd_val;
		r.bus_status = status;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing = RESET_TIMING;
			ph = PH_IDLE;
			ticks = '0;
			shreg = '0;
			rd_val = '0;
			bits_rem = '0;
			rd_mode = 1'b0;
			byte_mode = 1'b0;
			status = ST_PRESENCE_OK;
			owed_results.delete();
			errs = 0;
			seen = 0;
			failures <= 0;
			waiting <= 0;
			checked <= 0;
			bus_active <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				seen++;
				bus_active <= out_data.busy_res;
				if (owed_results.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("%0t: result item %0d arrived with nothing expected (%h)",
							$time, seen, out_data);
					end
				end else begin
					want = owed_results.pop_front();
					if (out_data !== want) begin
						errs++;
						if (errs <= 10) begin
							$display({"%0t: result item %0d, expected/actual: drive_low %b/%b ",
								"busy %b/%b done %b/%b read_data %h/%h bus_status %0d/%0d"},
								$time, seen, want.drive_low, out_data.drive_low,
								want.busy_res, out_data.busy_res, want.done_res, out_data.done_res,
								want.read_data, out_data.read_data,
								want.bus_status, out_data.bus_status);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RESET_LOW: timing.reset_low_time = cfg_data;
					REG_PRESENCE_WAIT: timing.presence_wait_time = cfg_data;
					REG_PRESENCE_END: timing.presence_end_time = cfg_data;
					REG_WRITE_ONE_LOW: timing.write_one_low_time = cfg_data;
					REG_WRITE_ZERO_LOW: timing.write_zero_low_time = cfg_data;
					REG_READ_LOW: timing.read_low_time = cfg_data;
					REG_READ_SAMPLE: timing.read_sample_time = cfg_data;
					REG_SLOT: timing.slot_time = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				bus_tick(in_data, predicted);
				owed_results.push_back(predicted);
			end
			failures <= errs;
			waiting <= owed_results.size();
			checked <= seen;
		end
	end

endmodule

// ===== dv/tb_onewire_bus_master_top.sv =====
`timescale 1ns / 1ps

module tb_onewire_bus_master_top;
	import owbm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_TICKS = 200;
	localparam logic [OP_WIDTH-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_WIDTH-1:0] OP_SPARE_HI = 3'd7;
	localparam cfg_t RESET_TIMING = '{
		reset_low_time: 10'd480, presence_wait_time: 10'd40, presence_end_time: 10'd300,
		write_one_low_time: 10'd5, write_zero_low_time: 10'd60, read_low_time: 10'd5,
		read_sample_time: 10'd10, slot_time: 10'd61
	};
	localparam cfg_t SKEWED_TIMING = '{
		reset_low_time: 10'd3, presence_wait_time: 10'd2, presence_end_time: 10'd4,
		write_one_low_time: 10'd30, write_zero_low_time: 10'd1, read_low_time: 10'd3,
		read_sample_time: 10'd40, slot_time: 10'd20
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	in_item_t                   in_data = '0;
	logic                       out_ready = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0]       cfg_data = '0;
	logic                       in_ready;
	logic                       out_valid;
	logic                       cfg_ready;
	out_item_t                  out_data;
	int                         failures;
	int                         waiting;
	int                         checked;
	logic                       bus_active;

	cfg_t timing = RESET_TIMING;
	int   ticks_sent = 0;
	int   commands_sent = 0;
	int   settings_used = 1;
	int   burst_left = 0;
	int   idle_cycles = 0;

	always #6 clk = ~clk;

	onewire_bus_master_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	onewire_bus_checker bus_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.waiting(waiting),
		.checked(checked),
		.bus_active(bus_active)
	);

	function automatic int ticks_of(input logic [CFG_WIDTH-1:0] v);
		return (v == '0) ? 1 : int'(v);
	endfunction

	// Rough length of a command, used only to place the next one near its end.
	function automatic int command_ticks(input logic [OP_WIDTH-1:0] op);
		int slot;
		slot = (timing.slot_time < 2) ? 2 : int'(timing.slot_time);
		case (op)
			OP_RESET: return ticks_of(timing.reset_low_time) + ticks_of(timing.presence_wait_time)
				+ ticks_of(timing.presence_end_time);
			OP_WRITE_BIT, OP_READ_BIT: return slot;
			OP_WRITE_BYTE, OP_READ_BYTE: return BITS_PER_BYTE * slot;
			default: return 0;
		endcase
	endfunction

	function automatic logic [OP_WIDTH-1:0] pick_command();
		case ($urandom_range(0, 4))
			0: return OP_RESET;
			1: return OP_WRITE_BIT;
			2: return OP_READ_BIT;
			3: return OP_WRITE_BYTE;
			default: return OP_READ_BYTE;
		endcase
	endfunction

	function automatic logic [CFG_WIDTH-1:0] pick_low();
		return ($urandom_range(0, 7) == 0) ? CFG_WIDTH'($urandom_range(0, 1023))
			: CFG_WIDTH'($urandom_range(0, 12));
	endfunction

	function automatic cfg_t random_timing();
		cfg_t t;
		t.reset_low_time = CFG_WIDTH'($urandom_range(0, 16));
		t.presence_wait_time = CFG_WIDTH'($urandom_range(0, 16));
		t.presence_end_time = CFG_WIDTH'($urandom_range(0, 16));
		t.write_one_low_time = pick_low();
		t.write_zero_low_time = pick_low();
		t.read_low_time = pick_low();
		t.read_sample_time = pick_low();
		t.slot_time = CFG_WIDTH'($urandom_range(0, 24));
		return t;
	endfunction

	task automatic send_tick(input logic [OP_WIDTH-1:0] op, input logic [DATA_WIDTH-1:0] wd);
		int gap;
		logic line;
		line = 1'($urandom_range(0, 1));
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= '{operation: op, write_data: wd, line_level: line};
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	task automatic run_command(input logic [OP_WIDTH-1:0] op, input logic [DATA_WIDTH-1:0] wd);
		int filler;
		send_tick(op, wd);
		commands_sent++;
		filler = command_ticks(op) + int'($urandom_range(0, 3)) - 2;
		repeat (filler) begin
			send_tick(($urandom_range(0, 9) == 0) ? OP_WIDTH'($urandom_range(0, 7)) : OP_NONE,
				DATA_WIDTH'($urandom));
		end
	endtask

	// Keeps ticking until every result is back and the last one shows the bus idle.
	task automatic drain_to_idle();
		in_valid <= 1'b0;
		forever begin
			@(posedge clk);
			if (waiting == 0 && !bus_active) begin
				break;
			end
			if (waiting == 0) begin
				repeat (4) send_tick(OP_NONE, '0);
				in_valid <= 1'b0;
			end
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_timing(input cfg_t t);
		drain_to_idle();
		write_reg(REG_RESET_LOW, t.reset_low_time);
		write_reg(REG_PRESENCE_WAIT, t.presence_wait_time);
		write_reg(REG_PRESENCE_END, t.presence_end_time);
		write_reg(REG_WRITE_ONE_LOW, t.write_one_low_time);
		write_reg(REG_WRITE_ZERO_LOW, t.write_zero_low_time);
		write_reg(REG_READ_LOW, t.read_low_time);
		write_reg(REG_READ_SAMPLE, t.read_sample_time);
		write_reg(REG_SLOT, t.slot_time);
		cfg_valid <= 1'b0;
		timing = t;
		settings_used++;
	endtask

	initial begin
		int phase_end;
		int random_start;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_command(OP_WRITE_BIT, 8'h01);
		run_command(OP_READ_BIT, 8'hFF);

		apply_timing('0);
		run_command(OP_RESET, 8'h00);
		run_command(OP_WRITE_BIT, 8'hFE);
		run_command(OP_WRITE_BIT, 8'hFF);
		run_command(OP_READ_BIT, 8'h00);
		run_command(OP_WRITE_BYTE, 8'h00);
		run_command(OP_WRITE_BYTE, 8'hFF);
		run_command(OP_READ_BYTE, 8'h00);
		run_command(OP_READ_BYTE, 8'hFF);
		send_tick(OP_SPARE_LO, 8'hFF);
		send_tick(OP_SPARE_HI, 8'h00);
		send_tick(OP_NONE, 8'hAA);
		// The reset lands while the byte write is running and must be dropped.
		send_tick(OP_WRITE_BYTE, 8'hA5);
		run_command(OP_RESET, 8'h5A);

		apply_timing(SKEWED_TIMING);
		run_command(OP_READ_BIT, 8'h00);
		run_command(OP_WRITE_BYTE, 8'h0F);
		run_command(OP_READ_BYTE, 8'h00);

		random_start = ticks_sent;
		while (ticks_sent - random_start < RANDOM_TICKS) begin
			apply_timing(random_timing());
			phase_end = ticks_sent + int'($urandom_range(60, 140));
			while (ticks_sent < phase_end) begin
				if ($urandom_range(0, 9) < 8) begin
					run_command(pick_command(), DATA_WIDTH'($urandom));
				end else begin
					repeat ($urandom_range(1, 8)) begin
						send_tick(OP_WIDTH'($urandom_range(0, 7)), DATA_WIDTH'($urandom));
					end
				end
			end
		end

		drain_to_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d ticks with %0d commands over %0d timing settings; %0d results checked.",
			ticks_sent, commands_sent, settings_used, checked);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// The long hold-off early on lets the output fill and back up into the input.
	initial begin
		int mode;
		int span_len;
		while (!arst_n) @(posedge clk);
		repeat (300) begin
			out_ready <= ($urandom_range(0, 3) != 0);
			@(posedge clk);
		end
		out_ready <= 1'b0;
		repeat (200) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			span_len = $urandom_range(10, 80);
			repeat (span_len) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 5) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("No item moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/owbm_pkg.sv
rtl/owbm_engine.sv
rtl/onewire_bus_master_top.sv
dv/onewire_bus_checker.sv
dv/tb_onewire_bus_master_top.sv
